// File: rtl/bdpt_pkg.sv
// Shared types and constants for the button debounce / press timer.
// No dependencies; imported by bdpt_track and the top level.

package bdpt_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned CfgIdxW = 3;

	typedef logic [TimeW-1:0] ms_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_POLARITY_INVERT = 3'd0,
		REG_DEBOUNCE_MS     = 3'd1,
		REG_LONG_PRESS_MS   = 3'd2,
		REG_REPEAT_MS       = 3'd3,
		REG_RELEASE_HOLD_MS = 3'd4,
		REG_IDLE_MS         = 3'd5
	} cfg_reg_t;

	localparam logic RstPolarityInvert = 1'b1;
	localparam ms_t  RstDebounceMs     = 32'd10;
	localparam ms_t  RstLongPressMs    = 32'd1000;
	localparam ms_t  RstRepeatMs       = 32'd200;
	localparam ms_t  RstReleaseHoldMs  = 32'hFFFF_FFFF;
	localparam ms_t  RstIdleMs         = 32'd1000;

	typedef struct packed {
		logic polarity_invert;
		ms_t  debounce_ms;
		ms_t  long_press_ms;
		ms_t  repeat_ms;
		ms_t  release_hold_ms;
		ms_t  idle_ms;
	} cfg_t;

	typedef struct packed {
		ms_t  now_ms;
		logic raw_pressed;
	} sample_t;

	typedef struct packed {
		logic level;
		logic changed;
		logic press_pulse;
		logic short_release;
		logic long_release;
		logic long_press;
		logic repeat_pulse;
		logic idle_long;
		ms_t  change_time;
	} result_t;

endpackage

// File: rtl/bdpt_track.sv
// Debounce state and press timing: evaluates one sample against the held
// state and updates that state when the word advances. Uses bdpt_pkg.

module bdpt_track import bdpt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  cfg_t    cfg,
	input  sample_t sample,
	output result_t result
);

	logic level_q;
	ms_t  last_change_q;
	ms_t  press_start_q;
	ms_t  last_repeat_q;

	logic lvl;
	ms_t  since_change;
	ms_t  since_repeat;
	ms_t  held;
	logic unlocked;
	logic chg;
	logic new_level;
	logic lp;
	logic rep;
	logic idle;
	ms_t  change_time;

	always_comb begin
		lvl          = sample.raw_pressed ^ cfg.polarity_invert;
		since_change = sample.now_ms - last_change_q;
		since_repeat = sample.now_ms - last_repeat_q;
		held         = sample.now_ms - press_start_q;
		unlocked     = since_change >= cfg.debounce_ms;
		chg          = unlocked && (lvl != level_q);
		new_level    = chg ? lvl : level_q;
		change_time  = chg ? sample.now_ms : last_change_q;
		// a change restarts the interval, so elapsed time becomes zero
		lp   = new_level && (chg ? (cfg.long_press_ms == '0)
			: (since_change >= cfg.long_press_ms));
		rep  = lp && (since_repeat >= cfg.repeat_ms);
		idle = !new_level && (chg ? (cfg.idle_ms == '0)
			: (since_change >= cfg.idle_ms));

		result.level         = new_level;
		result.changed       = chg;
		result.press_pulse   = chg && new_level;
		result.short_release = chg && !new_level && (held < cfg.release_hold_ms);
		result.long_release  = chg && !new_level && (held >= cfg.release_hold_ms);
		result.long_press    = lp;
		result.repeat_pulse  = rep;
		result.idle_long     = idle;
		result.change_time   = change_time;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q       <= RstPolarityInvert;
			last_change_q <= '0;
			press_start_q <= '0;
			last_repeat_q <= '0;
		end else if (advance) begin
			level_q       <= new_level;
			last_change_q <= change_time;
			if (chg && lvl) begin
				press_start_q <= sample.now_ms;
			end
			if (rep) begin
				last_repeat_q <= sample.now_ms;
			end
		end
	end

endmodule

// File: rtl/button_debounce_press_timer_core.sv
// Top level of the button debounce / press timer: config registers, input
// register and result register around bdpt_track. Uses bdpt_pkg.
//
// Usage:
//   sample channel: sample_valid / sample_stall carry one word per sample,
//     a millisecond timestamp and the raw button level.
//   result channel: result_valid / result_stall return exactly one result
//     word per sample, in order.
//   cfg channel: cfg_valid / cfg_ready (always ready) write register
//     cfg_index with cfg_data; indexes above five are dropped. Write only
//     while no sample is in flight.
// A sample passes from the input register through the evaluation stage into
// the result register, where result_valid marks its word. One sample is
// taken every cycle while sample_stall is low. The single evaluation stage
// between the input register and the result register also updates the
// debounce state.
// Reset loads the documented register defaults, sets the debounced level to
// the RstPolarityInvert value (1) and clears the tracker's held timestamps.
// When the receiver stalls, the result word holds, the input register holds
// its word, and sample_stall rises once both are full.

module button_debounce_press_timer_core import bdpt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  sample_t            sample,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  ms_t                cfg_data
);

	cfg_t    cfg_q;
	logic    valid_s1;
	sample_t sample_s1;
	logic    result_valid_q;
	result_t result_q;
	result_t eval;
	logic    out_open;
	logic    advance;

	assign cfg_ready    = 1'b1;
	assign out_open     = !result_valid_q || !result_stall;
	assign advance      = valid_s1 && out_open;
	assign sample_stall = valid_s1 && !out_open;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.polarity_invert <= RstPolarityInvert;
			cfg_q.debounce_ms     <= RstDebounceMs;
			cfg_q.long_press_ms   <= RstLongPressMs;
			cfg_q.repeat_ms       <= RstRepeatMs;
			cfg_q.release_hold_ms <= RstReleaseHoldMs;
			cfg_q.idle_ms         <= RstIdleMs;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_POLARITY_INVERT: cfg_q.polarity_invert <= cfg_data[0];
				REG_DEBOUNCE_MS:     cfg_q.debounce_ms     <= cfg_data;
				REG_LONG_PRESS_MS:   cfg_q.long_press_ms   <= cfg_data;
				REG_REPEAT_MS:       cfg_q.repeat_ms       <= cfg_data;
				REG_RELEASE_HOLD_MS: cfg_q.release_hold_ms <= cfg_data;
				REG_IDLE_MS:         cfg_q.idle_ms         <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register: take a new word whenever the held one moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	bdpt_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cfg     (cfg_q),
		.sample  (sample_s1),
		.result  (eval)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_open) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= eval;
		end
	end

`ifndef SYNTH
	a_press_is_change: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.press_pulse |-> result.changed && result.level)
		else $error("press pulse without a change to pressed");

	a_release_split: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.short_release && result.long_release))
		else $error("short and long release both set");

	a_repeat_needs_long: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.repeat_pulse |-> result.long_press)
		else $error("repeat pulse outside a long press");

	a_long_idle_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.long_press && result.idle_long))
		else $error("long press and idle both set");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1 && result_valid && result_stall)
		else $error("input stalled while the pipeline has room");
`endif

endmodule
